// ===== rtl/srfc_pkg.sv =====
`default_nettype none
package srfc_pkg;

  localparam int NUM_KINDS = 4;
  localparam int KIND_W = 2;
  localparam int CHAN_W = 2;
  localparam int SAMPLE_W = 32;
  localparam int REPEAT_W = 8;
  localparam int NUM_LIMIT_REGS = 2 * NUM_KINDS;
  localparam int LIMIT_IDX_W = $clog2(NUM_LIMIT_REGS);

  localparam int DEF_CHANNELS_PER_KIND = 4;
  localparam int DEF_FREEZE_LIMIT = 100;

  localparam logic [REPEAT_W-1:0] REPEAT_MAX = {REPEAT_W{1'b1}};

  // Limit register index is {kind, select}
  localparam logic LIMIT_SEL_LOW  = 1'b0;
  localparam logic LIMIT_SEL_HIGH = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] LIMIT_LOW_RESET  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] LIMIT_HIGH_RESET = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic [KIND_W-1:0]          sensor_kind;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind_out;
    logic [CHAN_W-1:0] channel_out;
    logic              range_fault;
    logic              freeze_fault;
    logic              channel_faulty;
  } out_item_t;

  typedef struct packed {
    logic chan_ok;
    logic freeze_fault;
  } freeze_status_t;

endpackage
`default_nettype wire

// ===== rtl/sensor_range_freeze_check.sv =====
// Accepted beats wait in the input register (s1_item); results load into out_data.
// Throughput: one beat per cycle while the output is not stalled; each sample is checked in a single pass
// between the input register and the result register, the per-channel
// state being updated as the beat moves into the result register.
// Reset (rst, synchronous): limits open to the full range, per-channel state cleared.
`default_nettype none
module sensor_range_freeze_check #(
  parameter int CHANNELS_PER_KIND = srfc_pkg::DEF_CHANNELS_PER_KIND,
  parameter int FREEZE_LIMIT      = srfc_pkg::DEF_FREEZE_LIMIT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [srfc_pkg::LIMIT_IDX_W-1:0] cfg_index,
  input  wire logic [srfc_pkg::SAMPLE_W-1:0]    cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire srfc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output srfc_pkg::out_item_t                   out_data
);
  import srfc_pkg::*;

  logic           s1_valid;
  in_item_t       s1_item;
  logic           advance;
  logic           range_fault;
  freeze_status_t fz;
  out_item_t      result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  srfc_range u_range (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .kind        (s1_item.sensor_kind),
    .sample      (s1_item.sample),
    .range_fault (range_fault)
  );

  srfc_freeze #(
    .CHANNELS_PER_KIND (CHANNELS_PER_KIND),
    .FREEZE_LIMIT      (FREEZE_LIMIT)
  ) u_freeze (
    .clk     (clk),
    .rst     (rst),
    .update  (advance),
    .kind    (s1_item.sensor_kind),
    .channel (s1_item.channel),
    .sample  (s1_item.sample),
    .status  (fz)
  );

  always_comb begin
    result.kind_out       = s1_item.sensor_kind;
    result.channel_out    = s1_item.channel;
    result.range_fault    = fz.chan_ok && range_fault;
    result.freeze_fault   = fz.freeze_fault;
    result.channel_faulty = result.range_fault || result.freeze_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // Hold the staged beat while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("staged beat lost or changed while stalled");

  a_faulty_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.channel_faulty ==
                  (out_data.range_fault || out_data.freeze_fault))
    else $error("channel_faulty disagrees with fault bits");

  a_bad_chan_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (int'(out_data.channel_out) >= CHANNELS_PER_KIND)
    |-> !out_data.range_fault && !out_data.freeze_fault)
    else $error("fault reported for channel beyond kind's count");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

endmodule
`default_nettype wire

// ===== rtl/srfc_range.sv =====
`default_nettype none
module srfc_range (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [srfc_pkg::LIMIT_IDX_W-1:0]      cfg_index,
  input  wire logic [srfc_pkg::SAMPLE_W-1:0]         cfg_data,
  input  wire logic [srfc_pkg::KIND_W-1:0]           kind,
  input  wire logic signed [srfc_pkg::SAMPLE_W-1:0]  sample,
  output logic                                       range_fault
);
  import srfc_pkg::*;

  logic signed [SAMPLE_W-1:0] limit [NUM_LIMIT_REGS];
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LIMIT_REGS; i++) begin
        limit[i] <= i[0] ? LIMIT_HIGH_RESET : LIMIT_LOW_RESET;
      end
    end else if (cfg_we) begin
      limit[cfg_index] <= $signed(cfg_data);
    end
  end

  always_comb begin
    lo = limit[{kind, LIMIT_SEL_LOW}];
    hi = limit[{kind, LIMIT_SEL_HIGH}];
    range_fault = (sample > hi) || (sample < lo);
  end

endmodule
`default_nettype wire

// ===== rtl/srfc_freeze.sv =====
`default_nettype none
module srfc_freeze #(
  parameter int CHANNELS_PER_KIND = srfc_pkg::DEF_CHANNELS_PER_KIND,
  parameter int FREEZE_LIMIT      = srfc_pkg::DEF_FREEZE_LIMIT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 update,
  input  wire logic [srfc_pkg::KIND_W-1:0]          kind,
  input  wire logic [srfc_pkg::CHAN_W-1:0]          channel,
  input  wire logic [srfc_pkg::SAMPLE_W-1:0]        sample,
  output srfc_pkg::freeze_status_t                  status
);
  import srfc_pkg::*;

  localparam int SLOTS  = NUM_KINDS * CHANNELS_PER_KIND;
  localparam int SLOT_W = $clog2(SLOTS);

  logic [SAMPLE_W-1:0] last_sample  [SLOTS];
  logic [REPEAT_W-1:0] repeat_count [SLOTS];

  logic [SLOT_W-1:0]   slot;
  logic                chan_ok;
  logic                same;
  logic [REPEAT_W-1:0] count;
  logic [REPEAT_W-1:0] count_next;

  always_comb begin
    chan_ok = int'(channel) < CHANNELS_PER_KIND;
    slot    = SLOT_W'(int'(kind) * CHANNELS_PER_KIND + int'(channel));
    same    = chan_ok && (sample == last_sample[slot]);
    count   = repeat_count[slot];
    if (!same) begin
      count_next = '0;
    end else if (count == REPEAT_MAX) begin
      count_next = count;
    end else begin
      count_next = count + REPEAT_W'(1);
    end
    status.chan_ok      = chan_ok;
    status.freeze_fault = same && (count_next > REPEAT_W'(FREEZE_LIMIT));
  end

  // Channels beyond the kind's count leave the state alone
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        last_sample[i]  <= '0;
        repeat_count[i] <= '0;
      end
    end else if (update && chan_ok) begin
      repeat_count[slot] <= count_next;
      if (!same) begin
        last_sample[slot] <= sample;
      end
    end
  end

endmodule
`default_nettype wire
